### rtl/mhtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared types and constants of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int TICK_LIMIT       = 32;
   localparam int KEY_W            = 40;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_TICK   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_EXPIRED   = 3'd4
   } status_type;

   typedef struct packed {
      logic        live;
      logic [7:0]  handle;
      logic [31:0] expiry;
      logic [31:0] tag;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_SINGLE,
      MODE_REBUILD,
      MODE_TICK
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FIND,
      S_COMPACT,
      S_RB_NEXT,
      S_RB_LOAD,
      S_SD_RDL,
      S_SD_RDR,
      S_SD_CMP,
      S_SD_END,
      S_SU_RD,
      S_SU_CMP,
      S_TICK_RD,
      S_TICK_CHK,
      S_TICK_EMIT,
      S_POP,
      S_POP_LOAD,
      S_RESULT
   } state_type;

endpackage
`default_nettype wire

### rtl/mhtq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhtq_ram
// Heap entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module mhtq_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output      mhtq_pkg::entry_type rd_data,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire mhtq_pkg::entry_type wr_data
);
   import mhtq_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/mhtq_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhtq_cmp
// Shared ordering unit: compares two keys of expiry and handle.
// ----------------------------------------------------------------------------
module mhtq_cmp (
   input  wire logic [mhtq_pkg::KEY_W-1:0] a_key,
   input  wire logic [mhtq_pkg::KEY_W-1:0] b_key,
   output      logic                       a_lt_b
);
   import mhtq_pkg::*;

   // The expiry sits in the upper bits, so one unsigned compare orders by
   // expiry first and by handle on a tie.
   assign a_lt_b = (a_key < b_key);

endmodule
`default_nettype wire

### rtl/min_heap_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Binary min-heap of timers ordered by expiry then handle, with lazy delete.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    type, timer id, expiry, tag, now
//   rsp      out        rsp_valid/rsp_ready    status, expired id/tag, last
//
// One request is in work at a time; req_ready is high only while idle.
// A handle search scans the store linearly (single RAM read port); an add
// then sifts the new entry up level by level. A delete that compacts
// squeezes out the dead entries and then rebuilds with count/2 sifts
// down; an update rebuilds in the same way. A tick pops each expired
// entry from the root. Reset clears only the state, the fill and dead
// counts and the result valid; the entry store needs no sweep. A stalled
// result channel holds the sequencer in its emitting or result state.
// ----------------------------------------------------------------------------
module min_heap_timer_queue #(
   parameter int CAPACITY = mhtq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_timer_id,
   input  wire logic [31:0] req_expire_time,
   input  wire logic [31:0] req_user_tag,
   input  wire logic [31:0] req_now_time,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_expired_id,
   output      logic [31:0] rsp_expired_tag,
   output      logic        rsp_last
);
   import mhtq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam int NW = $clog2(TICK_LIMIT + 1);

   // Sequencer registers.
   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   req_code_type     op_ff, op_in;
   logic [7:0]       id_ff, id_in;
   logic [31:0]      exp_ff, exp_in;
   logic [31:0]      tag_ff, tag_in;
   logic [31:0]      now_ff, now_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    dead_ff, dead_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic [CW-1:0]    wr_ff, wr_in;
   logic [CW-1:0]    rb_ff, rb_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    idx_ff, idx_in;
   entry_type        cur_ff, cur_in;
   entry_type        best_ff, best_in;
   logic             left_ff, left_in;
   logic             rv_ff, rv_in;
   logic [NW-1:0]    n_ff, n_in;
   status_type       status_ff, status_in;

   // Result register.
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [7:0]       rsp_id_ff;
   logic [31:0]      rsp_tag_ff;
   logic             rsp_last_ff;
   logic             rsp_load;
   status_type       load_status;
   logic [7:0]       load_id;
   logic [31:0]      load_tag;
   logic             load_last;
   logic             out_free;

   // Memory and compare unit hookup.
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   entry_type        rd_data, wr_data;
   logic [KEY_W-1:0] cmp_a, cmp_b;
   logic             a_lt_b;

   // Index arithmetic, widened so that child indices never wrap.
   logic [XW-1:0]    count_x, left_x, right_x;
   logic [AW-1:0]    parent_idx;
   logic [CW-1:0]    wr_next;
   logic             match;

   mhtq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   mhtq_cmp u_cmp (
      .a_key  (cmp_a),
      .b_key  (cmp_b),
      .a_lt_b (a_lt_b)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign count_x    = XW'(count_ff);
   assign left_x     = {1'b0, idx_ff, 1'b1};
   assign right_x    = left_x + XW'(1);
   assign parent_idx = AW'((idx_ff - AW'(1)) >> 1);
   assign match      = pend_ff && rd_data.live && (rd_data.handle == id_ff);
   assign wr_next    = wr_ff + CW'(pend_ff && rd_data.live);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         dead_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dead_ff  <= dead_in;
      end
      mode_ff   <= mode_in;
      op_ff     <= op_in;
      id_ff     <= id_in;
      exp_ff    <= exp_in;
      tag_ff    <= tag_in;
      now_ff    <= now_in;
      scan_ff   <= scan_in;
      wr_ff     <= wr_in;
      rb_ff     <= rb_in;
      pend_ff   <= pend_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      best_ff   <= best_in;
      left_ff   <= left_in;
      rv_ff     <= rv_in;
      n_ff      <= n_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_status_ff <= load_status;
         rsp_id_ff     <= load_id;
         rsp_tag_ff    <= load_tag;
         rsp_last_ff   <= load_last;
      end
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      exp_in      = exp_ff;
      tag_in      = tag_ff;
      now_in      = now_ff;
      count_in    = count_ff;
      dead_in     = dead_ff;
      scan_in     = scan_ff;
      wr_in       = wr_ff;
      rb_in       = rb_ff;
      pend_in     = pend_ff;
      idx_in      = idx_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      left_in     = left_ff;
      rv_in       = rv_ff;
      n_in        = n_ff;
      status_in   = status_ff;
      req_ready   = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = cur_ff;
      rsp_load    = 1'b0;
      load_status = ST_OK;
      load_id     = '0;
      load_tag    = '0;
      load_last   = 1'b1;
      cmp_a       = {rd_data.expiry, rd_data.handle};
      cmp_b       = {cur_ff.expiry, cur_ff.handle};

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_code_type'(req_type);
               id_in   = req_timer_id;
               exp_in  = req_expire_time;
               tag_in  = req_user_tag;
               now_in  = req_now_time;
               scan_in = '0;
               pend_in = 1'b0;
               n_in    = '0;
               mode_in = MODE_SINGLE;
               if (req_code_type'(req_type) == REQ_TICK) begin
                  state_in = S_TICK_RD;
               end else if (req_code_type'(req_type) == REQ_ADD &&
                            count_x >= XW'(CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_RESULT;
               end else begin
                  state_in = S_FIND;
               end
            end
         end

         // Linear search for a live entry with the requested handle; the
         // read of one slot overlaps the check of the one before.
         S_FIND: begin
            if (match) begin
               wr_addr = AW'(scan_ff - CW'(1));
               case (op_ff)
                  REQ_DELETE: begin
                     wr_en        = 1'b1;
                     wr_data      = rd_data;
                     wr_data.live = 1'b0;
                     dead_in      = dead_ff + CW'(1);
                     if ((dead_ff + CW'(1)) >= (count_ff >> 1)) begin
                        scan_in  = '0;
                        pend_in  = 1'b0;
                        wr_in    = '0;
                        state_in = S_COMPACT;
                     end else begin
                        status_in = ST_OK;
                        state_in  = S_RESULT;
                     end
                  end
                  REQ_UPDATE: begin
                     wr_en          = 1'b1;
                     wr_data        = rd_data;
                     wr_data.expiry = exp_ff;
                     rb_in          = count_ff >> 1;
                     state_in       = S_RB_NEXT;
                  end
                  default: begin
                     status_in = ST_DUPLICATE;
                     state_in  = S_RESULT;
                  end
               endcase
            end else if (scan_ff == count_ff) begin
               if (op_ff == REQ_ADD) begin
                  cur_in   = '{live: 1'b1, handle: id_ff, expiry: exp_ff, tag: tag_ff};
                  idx_in   = AW'(count_ff);
                  count_in = count_ff + CW'(1);
                  state_in = S_SU_RD;
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_RESULT;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(scan_ff);
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end

         // Squeeze out dead entries, writing live ones to the front.
         S_COMPACT: begin
            if (pend_ff && rd_data.live) begin
               wr_en   = 1'b1;
               wr_addr = AW'(wr_ff);
               wr_data = rd_data;
            end
            wr_in = wr_next;
            if (scan_ff == count_ff) begin
               count_in = wr_next;
               dead_in  = '0;
               rb_in    = wr_next >> 1;
               state_in = S_RB_NEXT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(scan_ff);
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end

         S_RB_NEXT: begin
            if (rb_ff == '0) begin
               status_in = ST_OK;
               state_in  = S_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(rb_ff - CW'(1));
               rb_in    = rb_ff - CW'(1);
               state_in = S_RB_LOAD;
            end
         end

         S_RB_LOAD: begin
            cur_in   = rd_data;
            idx_in   = AW'(rb_ff);
            mode_in  = MODE_REBUILD;
            state_in = S_SD_RDL;
         end

         // Sift down: the moving entry stays in cur_ff while the hole
         // descends; it is written once its place is found.
         S_SD_RDL: begin
            if (left_x < count_x) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(left_x);
               state_in = S_SD_RDR;
            end else begin
               wr_en    = 1'b1;
               state_in = S_SD_END;
            end
         end

         S_SD_RDR: begin
            left_in = a_lt_b;
            best_in = a_lt_b ? rd_data : cur_ff;
            rv_in   = right_x < count_x;
            if (right_x < count_x) begin
               rd_en   = 1'b1;
               rd_addr = AW'(right_x);
            end
            state_in = S_SD_CMP;
         end

         S_SD_CMP: begin
            cmp_b = {best_ff.expiry, best_ff.handle};
            wr_en = 1'b1;
            if (rv_ff && a_lt_b) begin
               wr_data  = rd_data;
               idx_in   = AW'(right_x);
               state_in = S_SD_RDL;
            end else if (left_ff) begin
               wr_data  = best_ff;
               idx_in   = AW'(left_x);
               state_in = S_SD_RDL;
            end else begin
               state_in = S_SD_END;
            end
         end

         S_SD_END: begin
            case (mode_ff)
               MODE_REBUILD: state_in = S_RB_NEXT;
               MODE_TICK:    state_in = S_TICK_RD;
               default: begin
                  status_in = ST_OK;
                  state_in  = S_RESULT;
               end
            endcase
         end

         // Sift up of a new entry towards the root.
         S_SU_RD: begin
            if (idx_ff == '0) begin
               wr_en     = 1'b1;
               status_in = ST_OK;
               state_in  = S_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent_idx;
               state_in = S_SU_CMP;
            end
         end

         S_SU_CMP: begin
            cmp_a = {cur_ff.expiry, cur_ff.handle};
            cmp_b = {rd_data.expiry, rd_data.handle};
            wr_en = 1'b1;
            if (a_lt_b) begin
               wr_data  = rd_data;
               idx_in   = parent_idx;
               state_in = S_SU_RD;
            end else begin
               status_in = ST_OK;
               state_in  = S_RESULT;
            end
         end

         S_TICK_RD: begin
            if (count_ff == '0) begin
               status_in = ST_OK;
               state_in  = S_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_TICK_CHK;
            end
         end

         // Expired when now is not earlier than the expiry; padding both
         // keys with equal handle bits turns the less-than into that test.
         S_TICK_CHK: begin
            cmp_a = {now_ff, 8'hFF};
            cmp_b = {rd_data.expiry, 8'hFF};
            if (a_lt_b) begin
               status_in = ST_OK;
               state_in  = S_RESULT;
            end else if (rd_data.live) begin
               if (n_ff >= NW'(TICK_LIMIT)) begin
                  status_in = ST_OK;
                  state_in  = S_RESULT;
               end else begin
                  state_in = S_TICK_EMIT;
               end
            end else begin
               if (dead_ff != '0) begin
                  dead_in = dead_ff - CW'(1);
               end
               state_in = S_POP;
            end
         end

         S_TICK_EMIT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               load_status = ST_EXPIRED;
               load_id     = rd_data.handle;
               load_tag    = rd_data.tag;
               load_last   = 1'b0;
               n_in        = n_ff + NW'(1);
               state_in    = S_POP;
            end
         end

         // Remove the root: the last entry moves up and sifts down.
         S_POP: begin
            count_in = count_ff - CW'(1);
            if (count_ff > CW'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(count_ff - CW'(1));
               state_in = S_POP_LOAD;
            end else begin
               state_in = S_TICK_RD;
            end
         end

         S_POP_LOAD: begin
            cur_in   = rd_data;
            idx_in   = '0;
            mode_in  = MODE_TICK;
            state_in = S_SD_RDL;
         end

         S_RESULT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               load_status = status_ff;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_expired_id  = rsp_id_ff;
   assign rsp_expired_tag = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_x <= XW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_dead_bound: assert property (@(posedge clock) disable iff (reset)
      dead_ff <= count_ff)
      else $error("dead count exceeds entry count");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in work");

   a_final_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && out_free) |=> (rsp_valid && rsp_last && req_ready))
      else $error("closing result not presented on return to idle");
`endif

endmodule
`default_nettype wire
